// ===== rtl/nmit_pkg.sv =====
// package: payload types, widths and cofactor index tables for the normal matrix unit
`timescale 1ns / 1ps
package nmit_pkg;

  localparam int EW      = 24;
  localparam int PW      = 2 * EW;
  localparam int CW      = PW + 1;
  localparam int DW      = 75;
  localparam int LW      = 41;
  localparam int MAGW    = 48;
  localparam int REM_W   = 98;
  localparam int QW      = 24;
  localparam int NDIV    = 24;
  localparam int LO_W    = 25;
  localparam logic [LW-1:0] LIMIT_RESET = LW'(256);
  localparam logic [EW-1:0] SAT_POS = 24'h7fffff;
  localparam logic [EW-1:0] SAT_NEG = 24'h800000;

  typedef struct packed {
    logic signed [EW-1:0] in_c0r0;
    logic signed [EW-1:0] in_c1r0;
    logic signed [EW-1:0] in_c2r0;
    logic signed [EW-1:0] in_c0r1;
    logic signed [EW-1:0] in_c1r1;
    logic signed [EW-1:0] in_c2r1;
    logic signed [EW-1:0] in_c0r2;
    logic signed [EW-1:0] in_c1r2;
    logic signed [EW-1:0] in_c2r2;
  } in_t;

  typedef struct packed {
    logic signed [EW-1:0] out_c0r0;
    logic signed [EW-1:0] out_c1r0;
    logic signed [EW-1:0] out_c2r0;
    logic signed [EW-1:0] out_c0r1;
    logic signed [EW-1:0] out_c1r1;
    logic signed [EW-1:0] out_c2r1;
    logic signed [EW-1:0] out_c0r2;
    logic signed [EW-1:0] out_c1r2;
    logic signed [EW-1:0] out_c2r2;
    logic                 mirrored;
    logic                 singular;
  } out_t;

  // entry k of the matrix sits at element 8-k
  typedef logic [8:0][EW-1:0] mat_t;

  // cofactor k = e[CA]*e[CB] - e[CC]*e[CD]
  localparam int CA [9] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int CB [9] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int CC [9] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int CD [9] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

endpackage

// ===== rtl/normal_matrix_inverse_transpose_top.sv =====
// normal matrix unit: pipelined 3x3 inverse transpose with exact determinant
// one beat per cycle sustained while the output beat is not stalled
// five arithmetic stages, 24 restoring divide stages (one quotient bit each), output stage
// the whole pipeline holds while the output beat is stalled
// synchronous reset clears all valid bits and sets limit to 256
`timescale 1ns / 1ps
module normal_matrix_inverse_transpose_top
  import nmit_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [LW-1:0] cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data
);

  logic          en;
  logic [LW-1:0] limit;

  logic                 v1, v2, v3, v4;
  mat_t                 m1, m2, m3, m4;
  logic signed [PW-1:0] p1 [9][2];
  logic signed [CW-1:0] cof2 [9];
  logic signed [CW-1:0] cof3 [9];
  logic signed [CW-1:0] cof4 [9];
  logic signed [PW+1:0] dlo3 [3];
  logic signed [PW-1:0] dhi3 [3];
  logic signed [DW-1:0] det4;

  logic                 dv    [0:NDIV];
  mat_t                 dm    [0:NDIV];
  logic [DW-1:0]        dmag  [0:NDIV];
  logic                 dneg  [0:NDIV];
  logic                 dsing [0:NDIV];
  logic [8:0]           qneg  [0:NDIV];
  logic [REM_W-1:0]     rem   [0:NDIV][9];
  logic [QW-1:0]        quo   [0:NDIV][9];

  logic [DW-1:0]        dmag_next;
  logic [EW-1:0]        res [9];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_data;
    end
  end

  // stage 1: cofactor products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= mat_t'(in_data);
      for (int k = 0; k < 9; k++) begin
        p1[k][0] <= $signed(in_data[(8-CA[k])*EW +: EW]) * $signed(in_data[(8-CB[k])*EW +: EW]);
        p1[k][1] <= $signed(in_data[(8-CC[k])*EW +: EW]) * $signed(in_data[(8-CD[k])*EW +: EW]);
      end
    end
  end

  // stage 2: cofactors
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2 <= m1;
      for (int k = 0; k < 9; k++) begin
        cof2[k] <= CW'(p1[k][0]) - CW'(p1[k][1]);
      end
    end
  end

  // stage 3: determinant partial products, cofactor split in two halves
  always_ff @(posedge clk) begin
    if (en) begin
      m3   <= m2;
      cof3 <= cof2;
      for (int k = 0; k < 3; k++) begin
        dlo3[k] <= $signed(m2[8-k]) * $signed({1'b0, cof2[k][LO_W-1:0]});
        dhi3[k] <= $signed(m2[8-k]) * $signed(cof2[k][CW-1:LO_W]);
      end
    end
  end

  // stage 4: determinant
  always_ff @(posedge clk) begin
    if (en) begin
      m4   <= m3;
      cof4 <= cof3;
      det4 <= (DW'(dhi3[0]) <<< LO_W) + DW'(dlo3[0])
            + (DW'(dhi3[1]) <<< LO_W) + DW'(dlo3[1])
            + (DW'(dhi3[2]) <<< LO_W) + DW'(dlo3[2]);
    end
  end

  // stage 5: magnitude, singular test, dividends
  assign dmag_next = det4[DW-1] ? DW'(-det4) : DW'(det4);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm[0]    <= m4;
      dmag[0]  <= dmag_next;
      dneg[0]  <= det4[DW-1];
      dsing[0] <= (dmag_next == '0) || (dmag_next < DW'(limit));
      for (int k = 0; k < 9; k++) begin
        qneg[0][k] <= cof4[k][CW-1] ^ det4[DW-1];
        quo[0][k]  <= '0;
        rem[0][k]  <= REM_W'({(cof4[k][CW-1] ? MAGW'(-cof4[k]) : MAGW'(cof4[k])), 32'b0});
      end
    end
  end

  // restoring divide, top bit doubles as the saturation test
  for (genvar s = 0; s < NDIV; s++) begin : g_div
    localparam int J = NDIV - 1 - s;
    logic [REM_W-1:0] t;
    assign t = REM_W'(dmag[s]) << J;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s+1] <= 1'b0;
      end else if (en) begin
        dv[s+1] <= dv[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dm[s+1]    <= dm[s];
        dmag[s+1]  <= dmag[s];
        dneg[s+1]  <= dneg[s];
        dsing[s+1] <= dsing[s];
        qneg[s+1]  <= qneg[s];
        for (int k = 0; k < 9; k++) begin
          if (rem[s][k] >= t) begin
            rem[s+1][k] <= rem[s][k] - t;
            quo[s+1][k] <= quo[s][k] | (QW'(1) << J);
          end else begin
            rem[s+1][k] <= rem[s][k];
            quo[s+1][k] <= quo[s][k];
          end
        end
      end
    end
  end

  // output stage
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (dsing[NDIV]) begin
        res[k] = dm[NDIV][8-k];
      end else if (quo[NDIV][k][QW-1]) begin
        res[k] = qneg[NDIV][k] ? SAT_NEG : SAT_POS;
      end else if (qneg[NDIV][k]) begin
        res[k] = EW'(-{1'b0, quo[NDIV][k][QW-2:0]});
      end else begin
        res[k] = EW'({1'b0, quo[NDIV][k][QW-2:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.out_c0r0 <= res[0];
      out_data.out_c1r0 <= res[1];
      out_data.out_c2r0 <= res[2];
      out_data.out_c0r1 <= res[3];
      out_data.out_c1r1 <= res[4];
      out_data.out_c2r1 <= res[5];
      out_data.out_c0r2 <= res[6];
      out_data.out_c1r2 <= res[7];
      out_data.out_c2r2 <= res[8];
      out_data.mirrored <= dneg[NDIV];
      out_data.singular <= dsing[NDIV];
    end
  end

endmodule

// ===== tb/sv/normal_matrix_inverse_transpose_top_test.sv =====
// testbench: random and directed matrices through the normal matrix unit, checked against a local predictor
`timescale 1ns / 1ps
module normal_matrix_inverse_transpose_top_test;
  import nmit_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam logic [LW-1:0] LIMIT_MAX = LW'(64'd1099511627776);

  logic clk, rst;
  logic cfg_we;
  logic [LW-1:0] cfg_data;
  logic in_valid, in_stall;
  in_t in_data;
  logic out_valid, out_stall;
  out_t out_data;

  normal_matrix_inverse_transpose_top uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  in_t pending_mats[$];
  out_t expected_normals[$];
  logic [LW-1:0] limit_copy;
  bit idle_on, long_hold_req;
  int in_gap, out_gap, hold_count, quiet_cycles, errors;
  int n_sent, n_checked, n_singular, n_mirrored, n_sat;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic void add_mat(in_t x);
    pending_mats = {pending_mats, x};
  endfunction

  function automatic void add_expected(out_t x);
    expected_normals = {expected_normals, x};
  endfunction

  function automatic logic [EW-1:0] inverse_entry(longint cf, logic [127:0] dmag, bit dneg);
    logic [127:0] num, q;
    bit neg;
    neg = (cf < 0) ^ dneg;
    num = 128'(cf < 0 ? -cf : cf) << 32;
    q = num / dmag;
    if (q >= 128'h800000) return neg ? SAT_NEG : SAT_POS;
    return neg ? -q[EW-1:0] : q[EW-1:0];
  endfunction

  function automatic out_t normal_of(in_t x);
    mat_t m;
    longint e[9];
    longint cf[9];
    logic signed [127:0] det;
    logic [127:0] dmag;
    bit dneg, sing;
    out_t r;
    mat_t o;
    m = mat_t'(x);
    for (int k = 0; k < 9; k++) e[k] = longint'($signed(m[8-k]));
    cf[0] = e[4]*e[8] - e[5]*e[7];
    cf[1] = e[5]*e[6] - e[3]*e[8];
    cf[2] = e[3]*e[7] - e[4]*e[6];
    cf[3] = e[2]*e[7] - e[1]*e[8];
    cf[4] = e[0]*e[8] - e[2]*e[6];
    cf[5] = e[1]*e[6] - e[0]*e[7];
    cf[6] = e[1]*e[5] - e[2]*e[4];
    cf[7] = e[2]*e[3] - e[0]*e[5];
    cf[8] = e[0]*e[4] - e[1]*e[3];
    det = e[0]*cf[0] + e[1]*cf[1] + e[2]*cf[2];
    dneg = det[127];
    dmag = dneg ? -det : det;
    sing = (dmag == 0) || (dmag < {87'd0, limit_copy});
    for (int k = 0; k < 9; k++) o[8-k] = sing ? m[8-k] : inverse_entry(cf[k], dmag, dneg);
    r = {o, dneg, sing};
    return r;
  endfunction

  function automatic logic [EW-1:0] rand_entry(int mode);
    case (mode)
      0: return EW'($urandom);
      1: return EW'($urandom_range(0, 262143) - 131072);
      2: return EW'($urandom_range(0, 511) - 256);
      3: return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
      default: return ($urandom_range(0, 2) == 0) ? EW'($urandom) : '0;
    endcase
  endfunction

  function automatic in_t rand_mat();
    mat_t m;
    int mode, shape;
    mode = $urandom_range(0, 4);
    shape = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      m[8-k] = rand_entry($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : mode);
    end
    if (shape == 0) begin
      for (int c = 0; c < 3; c++) m[8-(3+c)] = m[8-c];
    end else if (shape == 1) begin
      for (int k = 0; k < 9; k++) m[8-k] = (k % 4 == 0) ? rand_entry(mode) : '0;
    end
    return in_t'(m);
  endfunction

  function automatic in_t diag_mat(logic [EW-1:0] a, logic [EW-1:0] b, logic [EW-1:0] c);
    mat_t m;
    m = '0;
    m[8] = a; m[4] = b; m[0] = c;
    return in_t'(m);
  endfunction

  task automatic queue_directed();
    mat_t m;
    add_mat('0);
    add_mat(diag_mat(24'h010000, 24'h010000, 24'h010000));
    add_mat(diag_mat(24'hff0000, 24'h010000, 24'h010000));
    add_mat(diag_mat(24'd1, 24'd1, 24'd1));
    add_mat(diag_mat(24'd256, 24'd256, 24'd256));
    add_mat(diag_mat(SAT_NEG, SAT_NEG, SAT_NEG));
    add_mat(diag_mat(SAT_POS, SAT_POS, SAT_POS));
    add_mat(diag_mat(SAT_POS, SAT_NEG, 24'h000100));
    add_mat({9{SAT_POS}});
    add_mat({9{SAT_NEG}});
    add_mat({9{24'hffffff}});
    m = '0;
    m[8] = SAT_NEG; m[6] = SAT_POS; m[4] = SAT_POS; m[2] = SAT_POS; m[0] = SAT_NEG;
    add_mat(in_t'(m));
    m = '0;
    m[7] = 24'h020000; m[3] = 24'h008000; m[0] = 24'hffc000;
    add_mat(in_t'(m));
    add_mat(diag_mat(24'd16, 24'd16, 24'd1));
  endtask

  task automatic run_phase(int count, bit directed);
    if (directed) queue_directed();
    for (int n = 0; n < count; n++) add_mat(rand_mat());
    wait (pending_mats.size() == 0 && expected_normals.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [LW-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    limit_copy = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        add_expected(normal_of(in_data));
        void'(pending_mats.pop_front());
        n_sent++;
      end
      if (in_valid && in_stall) begin
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_mats.size() > 0) begin
        if (idle_on && $urandom_range(0, 11) == 0) begin
          in_gap <= $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_mats[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    out_t exp_beat;
    mat_t got_m, exp_m;
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
      hold_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, out_data);
          errors++;
        end else begin
          exp_beat = expected_normals.pop_front();
          got_m = mat_t'(out_data[PW*4+EW+1:2]);
          exp_m = mat_t'(exp_beat[PW*4+EW+1:2]);
          for (int k = 0; k < 9; k++) begin
            if (got_m[8-k] !== exp_m[8-k]) begin
              $display("%0t: entry %0d expected %h actual %h", $time, k, exp_m[8-k], got_m[8-k]);
              errors++;
            end
          end
          if (out_data.mirrored !== exp_beat.mirrored) begin
            $display("%0t: mirrored expected %b actual %b", $time, exp_beat.mirrored,
                     out_data.mirrored);
            errors++;
          end
          if (out_data.singular !== exp_beat.singular) begin
            $display("%0t: singular expected %b actual %b", $time, exp_beat.singular,
                     out_data.singular);
            errors++;
          end
          n_singular += exp_beat.singular;
          n_mirrored += exp_beat.mirrored;
          for (int k = 0; k < 9; k++) begin
            if (!exp_beat.singular && (exp_m[8-k] == SAT_POS || exp_m[8-k] == SAT_NEG)) n_sat++;
          end
        end
      end
      if (long_hold_req && hold_count < LONG_HOLD) begin
        hold_count <= hold_count + 1;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_gap <= $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    limit_copy = LIMIT_RESET;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    errors = 0;
    n_sent = 0; n_checked = 0; n_singular = 0; n_mirrored = 0; n_sat = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    long_hold_req = 1'b1;
    run_phase(400, 1'b1);
    write_limit('0);
    run_phase(350, 1'b1);
    write_limit(LIMIT_MAX);
    run_phase(300, 1'b1);
    write_limit(LW'({$urandom, $urandom}) % (LIMIT_MAX + 1));
    run_phase(350, 1'b0);
    write_limit(LIMIT_RESET);
    idle_on = 1'b0;
    run_phase(200, 1'b0);
    $display("sent %0d matrices, checked %0d normal beats over 5 limit settings", n_sent, n_checked);
    $display("singular %0d, mirrored %0d, saturated entries %0d, errors %0d",
             n_singular, n_mirrored, n_sat, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
